// File: design/spd_pkg.sv
// Shared types and constants for the serial packet deframer.
// Depends on nothing; used by serial_packet_deframer.
package spd_pkg;

    // Result status codes reported with every received byte.
    typedef enum logic [2:0] {
        ST_BUSY   = 3'd0,
        ST_OK     = 3'd1,
        ST_WAIT   = 3'd2,
        ST_BADLEN = 3'd3,
        ST_BADSUM = 3'd4,
        ST_BADEND = 3'd5
    } status_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_START_BYTE = 2'd0,
        CFG_END_BYTE   = 2'd1,
        CFG_MAX_LENGTH = 2'd2
    } cfg_index_t;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned BYTE_W      = 8;

    // Register reset values.
    localparam logic [BYTE_W-1:0] START_BYTE_RESET = 8'h01;
    localparam logic [BYTE_W-1:0] END_BYTE_RESET   = 8'h04;
    localparam logic [BYTE_W-1:0] MAX_LENGTH_RESET = 8'd64;

    // Smallest legal frame: start, length, type, checksum, end.
    localparam logic [BYTE_W-1:0] MIN_FRAME_LEN = 8'd5;
    // Position of the first data byte in a frame.
    localparam logic [BYTE_W-1:0] DATA_START_POS = 8'd3;

endpackage

// File: design/serial_packet_deframer.sv
// Serial packet deframer top level: input register, frame parser and result register.
// Depends on spd_pkg for status codes, register indexes and frame constants.
//
//  Channel   Direction  Handshake           Payload
//  -------   ---------  ------------------  ---------------------------------------------
//  s_        in         s_valid / s_ready   s_rx_byte
//  m_        out        m_valid / m_ready   m_status, m_data_*, m_type_valid, m_frame_type,
//                                           m_length_valid, m_payload_length
//  cfg_      in         cfg_wr_en           cfg_addr, cfg_wdata (no read-back)
//
// One request is accepted per cycle while s_ready is high; each request yields exactly one
// result, passing the input register and then the result register. The rate is set by the
// two-stage register pipeline: the parser state is updated as a byte moves from the
// input register to the result register, so consecutive bytes see each other's state.
// A stall on the result side first fills the result register, then the input register,
// and only then drops s_ready. Reset (aresetn low, synchronous) empties both stages,
// returns the parser to waiting for a start byte and loads the register defaults.

module serial_packet_deframer (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [spd_pkg::BYTE_W-1:0]          s_rx_byte,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [2:0]                          m_status,
    output logic                                m_data_valid,
    output logic [spd_pkg::BYTE_W-1:0]          m_data_index,
    output logic [spd_pkg::BYTE_W-1:0]          m_data_byte,
    output logic                                m_type_valid,
    output logic [spd_pkg::BYTE_W-1:0]          m_frame_type,
    output logic                                m_length_valid,
    output logic [spd_pkg::BYTE_W-1:0]          m_payload_length,

    input  logic                                cfg_wr_en,
    input  logic [spd_pkg::CFG_INDEX_W-1:0]     cfg_addr,
    input  logic [spd_pkg::BYTE_W-1:0]          cfg_wdata
);

    localparam int unsigned W = spd_pkg::BYTE_W;

    // Configuration registers.
    logic [W-1:0] start_byte_reg;
    logic [W-1:0] end_byte_reg;
    logic [W-1:0] max_length_reg;

    // Input stage.
    logic         in_valid_reg;
    logic [W-1:0] in_byte_reg;

    // Parser state.
    logic [W-1:0] pos_reg,  pos_next;
    logic [W-1:0] sum_reg,  sum_next;
    logic [W-1:0] flen_reg, flen_next;

    // Result stage.
    logic             out_valid_reg;
    spd_pkg::status_t status_reg,  status_next;
    logic             dv_reg,      dv_next;
    logic [W-1:0]     di_reg,      di_next;
    logic [W-1:0]     db_reg,      db_next;
    logic             tv_reg,      tv_next;
    logic [W-1:0]     ft_reg,      ft_next;
    logic             lv_reg,      lv_next;
    logic [W-1:0]     pl_reg,      pl_next;

    logic out_free;
    logic move;

    // The input stage hands its byte on whenever the result stage is empty or is
    // being drained in this same cycle.
    assign out_free = !out_valid_reg || m_ready;
    assign move     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || move;

    // Frame parser. Positions are compared with one extra bit so that the checks
    // near the end of a maximum-length frame cannot wrap.
    always_comb begin
        logic [W:0] pos_ext;
        logic [W:0] flen_ext;
        logic       advance;

        pos_ext   = {1'b0, pos_reg};
        flen_ext  = {1'b0, flen_reg};
        advance   = 1'b1;

        pos_next    = pos_reg;
        sum_next    = sum_reg;
        flen_next   = flen_reg;
        status_next = spd_pkg::ST_BUSY;
        dv_next     = 1'b0;
        di_next     = '0;
        db_next     = '0;
        tv_next     = 1'b0;
        ft_next     = '0;
        lv_next     = 1'b0;
        pl_next     = '0;

        if (pos_reg == W'(0)) begin
            if (in_byte_reg != start_byte_reg) begin
                status_next = spd_pkg::ST_WAIT;
                advance     = 1'b0;
            end else begin
                sum_next = in_byte_reg;
            end
        end else if (pos_reg == W'(1)) begin
            if (in_byte_reg < spd_pkg::MIN_FRAME_LEN || in_byte_reg > max_length_reg) begin
                pos_next    = '0;
                status_next = spd_pkg::ST_BADLEN;
                advance     = 1'b0;
            end else begin
                sum_next  = sum_reg + in_byte_reg;
                flen_next = in_byte_reg;
                lv_next   = 1'b1;
                pl_next   = in_byte_reg - spd_pkg::MIN_FRAME_LEN;
            end
        end else if (pos_reg == W'(2)) begin
            tv_next  = 1'b1;
            ft_next  = in_byte_reg;
            sum_next = sum_reg + in_byte_reg;
        end else if (pos_ext + (W+1)'(2) == flen_ext) begin
            // Checksum byte.
            if (sum_reg != in_byte_reg) begin
                pos_next    = '0;
                status_next = spd_pkg::ST_BADSUM;
                advance     = 1'b0;
            end
        end else if (pos_ext + (W+1)'(1) == flen_ext) begin
            // End byte closes the frame either way.
            pos_next    = '0;
            status_next = (in_byte_reg == end_byte_reg) ? spd_pkg::ST_OK
                                                        : spd_pkg::ST_BADEND;
            advance     = 1'b0;
        end else begin
            dv_next  = 1'b1;
            di_next  = pos_reg - spd_pkg::DATA_START_POS;
            db_next  = in_byte_reg;
            sum_next = sum_reg + in_byte_reg;
        end

        if (advance) begin
            pos_next = pos_reg + W'(1);
        end
    end

    // Configuration writes; an index beyond the register list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_byte_reg <= spd_pkg::START_BYTE_RESET;
            end_byte_reg   <= spd_pkg::END_BYTE_RESET;
            max_length_reg <= spd_pkg::MAX_LENGTH_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                spd_pkg::CFG_START_BYTE: start_byte_reg <= cfg_wdata;
                spd_pkg::CFG_END_BYTE:   end_byte_reg   <= cfg_wdata;
                spd_pkg::CFG_MAX_LENGTH: max_length_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Pipeline control and parser state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            sum_reg       <= '0;
            flen_reg      <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (move) begin
                in_valid_reg <= 1'b0;
            end

            if (move) begin
                out_valid_reg <= 1'b1;
                pos_reg       <= pos_next;
                sum_reg       <= sum_next;
                flen_reg      <= flen_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
        if (move) begin
            status_reg <= status_next;
            dv_reg     <= dv_next;
            di_reg     <= di_next;
            db_reg     <= db_next;
            tv_reg     <= tv_next;
            ft_reg     <= ft_next;
            lv_reg     <= lv_next;
            pl_reg     <= pl_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_status         = status_reg;
    assign m_data_valid     = dv_reg;
    assign m_data_index     = di_reg;
    assign m_data_byte      = db_reg;
    assign m_type_valid     = tv_reg;
    assign m_frame_type     = ft_reg;
    assign m_length_valid   = lv_reg;
    assign m_payload_length = pl_reg;

    // Any result other than "in progress" leaves the parser waiting for a start byte.
    a_idle_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (move && status_next != spd_pkg::ST_BUSY) |=> (pos_reg == '0))
        else $error("parser not back to waiting after a closing or error status");

    // A byte is at most one of length, type and data.
    a_one_role: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> $onehot0({dv_reg, tv_reg, lv_reg}))
        else $error("byte reported in more than one role");

    // A reported payload length agrees with the stored frame length.
    a_len_stored: assert property (@(posedge aclk) disable iff (!aresetn)
        (move && lv_next) |=> (flen_reg == pl_reg + spd_pkg::MIN_FRAME_LEN))
        else $error("stored frame length disagrees with reported payload length");

    // A byte in flight is never dropped while the result side stalls.
    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !move) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("input byte lost during a result stall");

endmodule

// File: verif/tb_serial_packet_deframer.sv
`timescale 1ns / 1ps
// Self-checking testbench for serial_packet_deframer: drives framed byte streams and checks
// every per-byte parse result. Depends on spd_pkg and the serial_packet_deframer RTL only.
module tb_serial_packet_deframer;

    localparam realtime CLK_PERIOD     = 12.0;
    localparam int      RESET_CYCLES   = 2;
    localparam int      MAX_GAP        = 12;
    // No request or result may go missing for this long; the longest correct quiet spell
    // is a chained stall, so this is a generous margin.
    localparam int      WATCHDOG_LIMIT = 2000;
    // The block answers through its input and result registers; let it settle before the verdict.
    localparam int      SETTLE_CYCLES  = 8;

    // Ways a generated frame can be broken on purpose.
    typedef enum int {
        FAULT_NONE,
        FAULT_LEN_LOW,
        FAULT_LEN_HIGH,
        FAULT_SUM,
        FAULT_END
    } frame_fault_t;

    // Everything the block reports for one received byte.
    typedef struct packed {
        spd_pkg::status_t           status;
        logic                       data_valid;
        logic [spd_pkg::BYTE_W-1:0] data_index;
        logic [spd_pkg::BYTE_W-1:0] data_byte;
        logic                       type_valid;
        logic [spd_pkg::BYTE_W-1:0] frame_type;
        logic                       length_valid;
        logic [spd_pkg::BYTE_W-1:0] payload_length;
    } byte_result_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_valid;
    logic                            s_ready;
    logic [spd_pkg::BYTE_W-1:0]      s_rx_byte;
    logic                            m_valid;
    logic                            m_ready;
    logic [2:0]                      m_status;
    logic                            m_data_valid;
    logic [spd_pkg::BYTE_W-1:0]      m_data_index;
    logic [spd_pkg::BYTE_W-1:0]      m_data_byte;
    logic                            m_type_valid;
    logic [spd_pkg::BYTE_W-1:0]      m_frame_type;
    logic                            m_length_valid;
    logic [spd_pkg::BYTE_W-1:0]      m_payload_length;
    logic                            cfg_wr_en;
    logic [spd_pkg::CFG_INDEX_W-1:0] cfg_addr;
    logic [spd_pkg::BYTE_W-1:0]      cfg_wdata;

    serial_packet_deframer dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_data_valid     (m_data_valid),
        .m_data_index     (m_data_index),
        .m_data_byte      (m_data_byte),
        .m_type_valid     (m_type_valid),
        .m_frame_type     (m_frame_type),
        .m_length_valid   (m_length_valid),
        .m_payload_length (m_payload_length),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #(CLK_PERIOD / 2);
        aclk = 1'b1;
        #(CLK_PERIOD / 2);
    end

    // Shadow copy of the register file, kept in step with every write we issue.
    logic [spd_pkg::BYTE_W-1:0] shadow_start   = spd_pkg::START_BYTE_RESET;
    logic [spd_pkg::BYTE_W-1:0] shadow_end     = spd_pkg::END_BYTE_RESET;
    logic [spd_pkg::BYTE_W-1:0] shadow_max_len = spd_pkg::MAX_LENGTH_RESET;

    // Parser state of the predictor: next byte position (0 means hunting for a start
    // byte), running checksum and the accepted total frame length.
    logic [spd_pkg::BYTE_W-1:0] parse_pos = '0;
    logic [spd_pkg::BYTE_W-1:0] parse_sum = '0;
    logic [spd_pkg::BYTE_W-1:0] parse_len = '0;

    byte_result_t pending_parse_results[$];

    bit src_gaps_on   = 1'b1;
    bit sink_stalls_on = 1'b1;

    int mismatches     = 0;
    int requests_sent  = 0;
    int results_seen   = 0;
    int frames_ok      = 0;
    int parse_errors   = 0;
    int settings_used  = 0;

    // Works out what the block must report for one accepted byte and advances the
    // predictor's parser state exactly as the hardware should.
    function automatic byte_result_t deframe_byte(input logic [spd_pkg::BYTE_W-1:0] rx);
        byte_result_t r;
        r        = '0;
        r.status = spd_pkg::ST_BUSY;
        if (parse_pos == 0) begin
            // Hunting: anything but the start byte is dropped with a waiting status.
            if (rx != shadow_start) begin
                r.status = spd_pkg::ST_WAIT;
            end else begin
                parse_sum = rx;
                parse_pos = 8'd1;
            end
        end else if (parse_pos == 1) begin
            if (rx < spd_pkg::MIN_FRAME_LEN || rx > shadow_max_len) begin
                parse_pos = 8'd0;
                r.status  = spd_pkg::ST_BADLEN;
            end else begin
                parse_sum        = parse_sum + rx;
                parse_len        = rx;
                r.length_valid   = 1'b1;
                r.payload_length = rx - spd_pkg::MIN_FRAME_LEN;
                parse_pos        = 8'd2;
            end
        end else if (parse_pos == 2) begin
            r.type_valid = 1'b1;
            r.frame_type = rx;
            parse_sum    = parse_sum + rx;
            parse_pos    = 8'd3;
        end else if (int'(parse_pos) + 2 == int'(parse_len)) begin
            // Checksum byte: the sum covers start, length, type and data only.
            if (parse_sum != rx) begin
                parse_pos = 8'd0;
                r.status  = spd_pkg::ST_BADSUM;
            end else begin
                parse_pos = parse_pos + 8'd1;
            end
        end else if (int'(parse_pos) + 1 == int'(parse_len)) begin
            parse_pos = 8'd0;
            r.status  = (rx == shadow_end) ? spd_pkg::ST_OK : spd_pkg::ST_BADEND;
        end else begin
            r.data_valid = 1'b1;
            r.data_index = parse_pos - spd_pkg::DATA_START_POS;
            r.data_byte  = rx;
            parse_sum    = parse_sum + rx;
            parse_pos    = parse_pos + 8'd1;
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Result checker: every accepted result is compared with the oldest prediction.
    always @(posedge aclk) begin
        byte_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (m_status == spd_pkg::ST_OK) begin
                frames_ok++;
            end else if (m_status != spd_pkg::ST_BUSY && m_status != spd_pkg::ST_WAIT) begin
                parse_errors++;
            end
            if (pending_parse_results.size() == 0) begin
                $error("result with status %0d arrived with no request outstanding",
                       m_status);
                mismatches++;
            end else begin
                want = pending_parse_results.pop_front();
                check_field("status",         want.status,         m_status);
                check_field("data_valid",     want.data_valid,     m_data_valid);
                check_field("data_index",     want.data_index,     m_data_index);
                check_field("data_byte",      want.data_byte,      m_data_byte);
                check_field("type_valid",     want.type_valid,     m_type_valid);
                check_field("frame_type",     want.frame_type,     m_frame_type);
                check_field("length_valid",   want.length_valid,   m_length_valid);
                check_field("payload_length", want.payload_length, m_payload_length);
            end
        end
    end

    // Result side back-pressure: random stall bursts while enabled; otherwise ready once any burst under way ends.
    initial begin
        int stall_left;
        stall_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_left > 0) begin
                stall_left--;
            end else if (sink_stalls_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, MAX_GAP);
            end
            m_ready <= (stall_left == 0);
        end
    end

    // Watchdog: too many cycles without any request or result moving ends the run.
    always @(posedge aclk) begin
        int quiet_cycles;
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: nothing moved for %0d cycles.", WATCHDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Offers one byte request, optionally after a random idle gap, and records the
    // prediction at the edge where it is accepted. Called and returns at a rising edge.
    task automatic send_byte(input logic [spd_pkg::BYTE_W-1:0] rx);
        if (src_gaps_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= rx;
        do @(posedge aclk); while (!s_ready);
        pending_parse_results.push_back(deframe_byte(rx));
        requests_sent++;
    endtask

    // Builds and sends one frame under the current register settings. A negative fill
    // gives random type and data bytes; otherwise every type and data byte is the fill.
    task automatic send_frame(input int data_len, input frame_fault_t fault,
                              input int fill = -1);
        logic [spd_pkg::BYTE_W-1:0] len_byte;
        logic [spd_pkg::BYTE_W-1:0] sum;
        logic [spd_pkg::BYTE_W-1:0] b;
        // Nothing is longer than 255, so an over-long length cannot be produced then.
        if (fault == FAULT_LEN_HIGH && shadow_max_len == 8'hFF) begin
            fault = FAULT_LEN_LOW;
        end
        case (fault)
            FAULT_LEN_LOW:
                len_byte = 8'($urandom_range(0, int'(spd_pkg::MIN_FRAME_LEN) - 1));
            FAULT_LEN_HIGH:
                len_byte = 8'($urandom_range(int'(shadow_max_len) + 1, 255));
            default:
                len_byte = 8'(data_len + int'(spd_pkg::MIN_FRAME_LEN));
        endcase
        send_byte(shadow_start);
        send_byte(len_byte);
        if (fault == FAULT_LEN_LOW || fault == FAULT_LEN_HIGH) begin
            return;
        end
        sum = shadow_start + len_byte;
        // The first pass of this loop sends the type byte, the rest send data.
        for (int i = -1; i < data_len; i++) begin
            b   = (fill < 0) ? 8'($urandom) : 8'(fill);
            sum = sum + b;
            send_byte(b);
        end
        send_byte(fault == FAULT_SUM ? sum ^ 8'($urandom_range(1, 255)) : sum);
        send_byte(fault == FAULT_END ? shadow_end ^ 8'($urandom_range(1, 255)) : shadow_end);
    endtask

    // Stops offering requests and waits until every predicted result has been checked;
    // with one result per request the block is then empty and safe to reconfigure.
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_parse_results.size() != 0) @(posedge aclk);
    endtask

    // Writes all three registers on consecutive edges; only called while the block is idle.
    task automatic set_config(input logic [spd_pkg::BYTE_W-1:0] start_val,
                              input logic [spd_pkg::BYTE_W-1:0] end_val,
                              input logic [spd_pkg::BYTE_W-1:0] max_len);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= spd_pkg::CFG_START_BYTE;
        cfg_wdata <= start_val;
        @(posedge aclk);
        cfg_addr  <= spd_pkg::CFG_END_BYTE;
        cfg_wdata <= end_val;
        @(posedge aclk);
        cfg_addr  <= spd_pkg::CFG_MAX_LENGTH;
        cfg_wdata <= max_len;
        @(posedge aclk);
        cfg_wr_en      <= 1'b0;
        shadow_start   = start_val;
        shadow_end     = end_val;
        shadow_max_len = max_len;
        settings_used++;
    endtask

    // Mostly well-formed frames with random content, mixed with broken frames and line
    // noise. Payloads are short most of the time, with an occasional long one.
    task automatic run_random(input int n_requests);
        int stop_at;
        int max_data;
        int data_len;
        int pick;
        stop_at  = requests_sent + n_requests;
        max_data = int'(shadow_max_len) - int'(spd_pkg::MIN_FRAME_LEN);
        while (requests_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 19) == 0) begin
                data_len = $urandom_range(0, max_data);
            end else begin
                data_len = $urandom_range(0, (max_data < 12) ? max_data : 12);
            end
            if (pick < 70) begin
                send_frame(data_len, FAULT_NONE);
            end else if (pick < 76) begin
                send_frame(data_len, FAULT_LEN_LOW);
            end else if (pick < 82) begin
                send_frame(data_len, FAULT_LEN_HIGH);
            end else if (pick < 88) begin
                send_frame(data_len, FAULT_SUM);
            end else if (pick < 94) begin
                send_frame(data_len, FAULT_END);
            end else begin
                send_byte(8'($urandom));
            end
        end
        drain();
    endtask

    // Reset register values: stray bytes while hunting, the shortest frame, a frame with
    // data, both kinds of bad length, a checksum error and a wrong end byte.
    task automatic test_directed_defaults();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(0, FAULT_NONE, 8'hFF);
        send_frame(2, FAULT_NONE, 8'h00);
        send_frame(0, FAULT_LEN_LOW);
        send_frame(0, FAULT_LEN_HIGH);
        send_frame(1, FAULT_SUM);
        send_frame(0, FAULT_END);
        drain();
    endtask

    // Register values at their limits, including the longest possible frame, a length
    // limit that only admits empty frames, and start and end bytes that are the same.
    task automatic test_register_extremes();
        set_config(8'h00, 8'hFF, 8'hFF);
        // 250 data bytes: data index and payload length reach their tops, the sum wraps.
        send_frame(250, FAULT_NONE);
        send_frame(0, FAULT_NONE, 8'h00);
        send_frame(3, FAULT_LEN_LOW);
        send_frame(4, FAULT_END);
        drain();

        set_config(8'hFF, 8'h00, spd_pkg::MIN_FRAME_LEN);
        send_frame(0, FAULT_NONE);
        send_frame(0, FAULT_LEN_HIGH);
        send_frame(0, FAULT_SUM);
        send_frame(0, FAULT_END);
        send_byte(8'h00);
        drain();

        // With equal start and end bytes a stray end byte opens a new frame.
        set_config(8'hA5, 8'hA5, 8'd10);
        send_frame(5, FAULT_NONE);
        send_frame(2, FAULT_SUM);
        send_frame(1, FAULT_NONE);
        send_frame(0, FAULT_NONE);
        drain();
    endtask

    // Random register settings, each followed by a stretch of random traffic with idling.
    task automatic test_random_traffic();
        for (int phase = 0; phase < 3; phase++) begin
            set_config(8'($urandom), 8'($urandom),
                       8'($urandom_range(int'(spd_pkg::MIN_FRAME_LEN), 255)));
            run_random(200);
        end
    endtask

    // Final stretch at full rate: no gaps on the request side, no stalls on results.
    task automatic test_back_to_back();
        src_gaps_on    = 1'b0;
        sink_stalls_on = 1'b0;
        set_config(spd_pkg::START_BYTE_RESET, spd_pkg::END_BYTE_RESET, 8'd20);
        run_random(250);
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_rx_byte <= '0;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= spd_pkg::CFG_START_BYTE;
        cfg_wdata <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_defaults();
        test_register_extremes();
        test_random_traffic();
        test_back_to_back();

        // Any result still to come, or one that should not come, shows up here.
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_parse_results.size() != 0) begin
            $error("%0d predicted results never arrived", pending_parse_results.size());
            mismatches++;
        end

        $display("Covered %0d byte requests and %0d checked results over %0d register settings.",
                 requests_sent, results_seen, settings_used);
        $display("Frames closed cleanly: %0d; length, checksum and end byte errors: %0d.",
                 frames_ok, parse_errors);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
design/spd_pkg.sv
design/serial_packet_deframer.sv
verif/tb_serial_packet_deframer.sv
